// ===== hdl/pcg_brg_pkg.sv =====
`timescale 1ns / 1ps
package pcg_brg_pkg;

  localparam logic [63:0] PCG_MULT       = 64'h5851_f42d_4c95_7f2d;
  localparam logic [63:0] PCG_STATE_INIT = 64'h853c_49e6_748f_ea9b;
  localparam logic [63:0] PCG_INC_INIT   = 64'hda3e_39cb_94b9_5bdb;

  localparam logic [1:0] OP_RESEED  = 2'd0;
  localparam logic [1:0] OP_DRAW    = 2'd1;
  localparam logic [1:0] OP_BOUNDED = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED,
    ST_ADV0,
    ST_ADV1,
    ST_ADV2,
    ST_ADV3,
    ST_ADV4,
    ST_SADD,
    ST_LMUL,
    ST_LCHK,
    ST_DIV,
    ST_DONE
  } seq_state_t;

  // XSH-RR output permutation of a state word
  function automatic logic [31:0] xsh_rr(input logic [63:0] s);
    logic [63:0] x;
    logic [31:0] mixed;
    logic [4:0]  rot;
    logic [63:0] dbl;
    x     = s ^ (s >> 18);
    mixed = x[58:27];
    rot   = s[63:59];
    dbl   = {mixed, mixed} >> rot;
    return dbl[31:0];
  endfunction

endpackage

// ===== hdl/pcg32_bounded_random_generator.sv =====
`timescale 1ns / 1ps
// PCG32 (XSH-RR) generator with reseed, raw draw and unbiased bounded draw.
// Requests enter on s_axis (tdata: op[1:0], range_low[33:2], range_high[65:34]);
// each request gives exactly one result on m_axis (tdata: raw_value[31:0],
// bounded_value[63:32]). The user writes the seed register through cfg_wr_en
// and cfg_wr_data only while the block is idle; the block does not enforce it.
// One 32x32 multiplier with a registered product serves every product: an LCG
// advance takes three passes through it plus a 64-bit add. A raw draw takes one
// advance, a reseed two with the seed added between; a bounded draw takes one
// advance, a multiply by the span and a check per draw tried, plus the bit-serial
// remainder and its recheck once when the first draw's low product is below the
// span. s_axis_tready is high only while the sequencer is idle, from the
// cycle after a result loads. The result sits in an output register, so the
// block takes the next request while m_axis waits; a finished result is held
// back until that register is free. Reset (rst, synchronous) restores the
// default state and increment, clears the seed and drops any pending result.
module pcg32_bounded_random_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // op[1:0], range_low[33:2], range_high[65:34]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // raw_value[31:0], bounded_value[63:32]
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data
);
  import pcg_brg_pkg::*;

  seq_state_t  state, state_next;
  logic [63:0] seed;
  logic [63:0] lcg, lcg_next;
  logic [63:0] inc, inc_next;
  logic [1:0]  op, op_next;
  logic [31:0] lo, lo_next;
  logic [31:0] range, range_next;
  logic [31:0] raw, raw_next;
  logic        reseed_pass, reseed_pass_next;
  logic        thr_ok, thr_ok_next;
  logic [63:0] prod, prod_next;
  logic [63:0] acc, acc_next;
  logic [31:0] rem, rem_next;
  logic [31:0] dvd, dvd_next;
  logic [4:0]  cnt, cnt_next;
  logic        out_valid, out_valid_next;
  logic [63:0] out_data, out_data_next;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [32:0] rem_shift;
  logic [32:0] rem_diff;
  logic        out_free;

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign out_free      = !out_valid || m_axis_tready;

  assign rem_shift = {rem, dvd[31]};
  assign rem_diff  = rem_shift - {1'b0, range};

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  always_comb begin
    case (state)
      ST_ADV0: begin
        mul_a = lcg[31:0];
        mul_b = PCG_MULT[31:0];
      end
      ST_ADV1: begin
        mul_a = lcg[31:0];
        mul_b = PCG_MULT[63:32];
      end
      ST_ADV2: begin
        mul_a = lcg[63:32];
        mul_b = PCG_MULT[31:0];
      end
      default: begin
        mul_a = raw;
        mul_b = range;
      end
    endcase
  end

  always_comb begin
    state_next       = state;
    lcg_next         = lcg;
    inc_next         = inc;
    op_next          = op;
    lo_next          = lo;
    range_next       = range;
    raw_next         = raw;
    reseed_pass_next = reseed_pass;
    thr_ok_next      = thr_ok;
    prod_next        = prod;
    acc_next         = acc;
    rem_next         = rem;
    dvd_next         = dvd;
    cnt_next         = cnt;
    out_valid_next   = out_valid && !m_axis_tready;
    out_data_next    = out_data;

    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_next          = s_axis_tdata[1:0];
          lo_next          = s_axis_tdata[33:2];
          range_next       = s_axis_tdata[65:34] - s_axis_tdata[33:2] + 32'd1;
          raw_next         = '0;
          reseed_pass_next = 1'b0;
          thr_ok_next      = 1'b0;
          case (s_axis_tdata[1:0])
            OP_RESEED:  state_next = ST_SEED;
            OP_DRAW:    state_next = ST_ADV0;
            OP_BOUNDED: state_next = ST_ADV0;
            default:    state_next = ST_DONE;
          endcase
        end
      end
      ST_SEED: begin
        lcg_next   = '0;
        inc_next   = {seed[62:0], 1'b1};
        state_next = ST_ADV0;
      end
      ST_ADV0: begin
        // the draw is taken from the state before the advance
        if (op != OP_RESEED) begin
          raw_next = xsh_rr(lcg);
        end
        prod_next  = mul_p;
        state_next = ST_ADV1;
      end
      ST_ADV1: begin
        acc_next   = prod;
        prod_next  = mul_p;
        state_next = ST_ADV2;
      end
      ST_ADV2: begin
        acc_next[63:32] = acc[63:32] + prod[31:0];
        prod_next       = mul_p;
        state_next      = ST_ADV3;
      end
      ST_ADV3: begin
        acc_next[63:32] = acc[63:32] + prod[31:0];
        state_next      = ST_ADV4;
      end
      ST_ADV4: begin
        lcg_next = acc + (inc | 64'd1);
        case (op)
          OP_RESEED:  state_next = reseed_pass ? ST_DONE : ST_SADD;
          OP_BOUNDED: state_next = ST_LMUL;
          default:    state_next = ST_DONE;
        endcase
      end
      ST_SADD: begin
        lcg_next         = lcg + seed;
        reseed_pass_next = 1'b1;
        state_next       = ST_ADV0;
      end
      ST_LMUL: begin
        prod_next  = mul_p;
        state_next = ST_LCHK;
      end
      ST_LCHK: begin
        if (thr_ok) begin
          state_next = (prod[31:0] < rem) ? ST_ADV0 : ST_DONE;
        end else if (range != 32'd0 && prod[31:0] < range) begin
          // threshold is (2^32 - range) mod range
          rem_next   = '0;
          dvd_next   = 32'd0 - range;
          cnt_next   = '0;
          state_next = ST_DIV;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DIV: begin
        rem_next = rem_diff[32] ? rem_shift[31:0] : rem_diff[31:0];
        dvd_next = {dvd[30:0], 1'b0};
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd31) begin
          thr_ok_next = 1'b1;
          state_next  = ST_LCHK;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_next      = 1'b1;
          out_data_next[31:0] = raw;
          out_data_next[63:32] = (op == OP_BOUNDED) ? lo + prod[63:32] : 32'd0;
          state_next          = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seed      <= '0;
      lcg       <= PCG_STATE_INIT;
      inc       <= PCG_INC_INIT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      lcg       <= lcg_next;
      inc       <= inc_next;
      out_valid <= out_valid_next;
      if (cfg_wr_en) begin
        seed <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op          <= op_next;
    lo          <= lo_next;
    range       <= range_next;
    raw         <= raw_next;
    reseed_pass <= reseed_pass_next;
    thr_ok      <= thr_ok_next;
    prod        <= prod_next;
    acc         <= acc_next;
    rem         <= rem_next;
    dvd         <= dvd_next;
    cnt         <= cnt_next;
    out_data    <= out_data_next;
  end

endmodule

// ===== hdl/pcg_brg_checker.sv =====
`timescale 1ns / 1ps
module pcg_brg_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  // no result survives a reset
  a_reset_clears: assert property (@(posedge clk) (!rst && $past(rst)) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  // an accepted request leaves the sequencer busy in the cycle after it
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("ready held across an accepted request");

  // a new result is loaded only as the sequencer returns to idle
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result appeared while sequencer busy");

  // hold the result while the receiver stalls
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind pcg32_bounded_random_generator pcg_brg_checker u_pcg_brg_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import pcg_brg_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] raw;
    logic [31:0] bounded;
  } draw_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;  // op, range_low, range_high, zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;       // raw_value, bounded_value
  logic        cfg_wr_en = 1'b0;
  logic [63:0] cfg_wr_data = '0;

  // generator model
  logic [63:0] gen_state = PCG_STATE_INIT;
  logic [63:0] gen_inc = PCG_INC_INIT;
  logic [63:0] seed_reg = '0;

  draw_result_t pending_results[$];
  draw_result_t want;
  int error_count = 0;
  int cycle_count = 0;

  // sender burst control
  bit gaps_on = 1'b1;
  int burst_left = 0;

  // receiver stall control
  int hold_off_req = 0;
  int hold_off_left = 0;
  logic [31:0] stall_pattern = '1;
  logic [4:0] pattern_pos = '0;
  int pattern_age = 0;

  pcg32_bounded_random_generator uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // advance the LCG and return the permuted word of the old state
  function automatic logic [31:0] lcg_advance();
    logic [63:0] prev;
    logic [31:0] mixed;
    logic [4:0]  rot;
    prev = gen_state;
    gen_state = prev * PCG_MULT + (gen_inc | 64'd1);
    mixed = 32'((prev ^ (prev >> 18)) >> 27);
    rot = prev[63:59];
    return (mixed >> rot) | (mixed << (5'd0 - rot));
  endfunction

  function automatic draw_result_t predict_result(input logic [1:0] op,
                                                  input logic [31:0] lo,
                                                  input logic [31:0] hi);
    draw_result_t r;
    logic [31:0] span;
    logic [31:0] thresh;
    logic [63:0] prod;
    r = '0;
    r.op = op;
    case (op)
      OP_RESEED: begin
        gen_state = '0;
        gen_inc = {seed_reg[62:0], 1'b1};
        void'(lcg_advance());
        gen_state = gen_state + seed_reg;
        void'(lcg_advance());
      end
      OP_DRAW: r.raw = lcg_advance();
      OP_BOUNDED: begin
        span = hi - lo + 32'd1;
        r.raw = lcg_advance();
        prod = {32'd0, r.raw} * {32'd0, span};
        // reject draws in the biased band; a zero span is the full 32-bit range
        if (span != 32'd0 && prod[31:0] < span) begin
          thresh = (32'd0 - span) % span;
          while (prod[31:0] < thresh) begin
            r.raw = lcg_advance();
            prod = {32'd0, r.raw} * {32'd0, span};
          end
        end
        r.bounded = lo + prod[63:32];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_error(input string msg);
    $display("[%0d] mismatch: %s", cycle_count, msg);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_error($sformatf("result %h with no request outstanding", m_axis_tdata));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[31:0] !== want.raw)
          report_error($sformatf("op %0d raw_value got %h want %h",
                                 want.op, m_axis_tdata[31:0], want.raw));
        if (m_axis_tdata[63:32] !== want.bounded)
          report_error($sformatf("op %0d bounded_value got %h want %h",
                                 want.op, m_axis_tdata[63:32], want.bounded));
      end
    end
  end

  // receiver: long hold-off on request, otherwise a rotating stall pattern
  always @(negedge clk) begin
    if (hold_off_req != 0) begin
      hold_off_left = hold_off_req;
      hold_off_req = 0;
    end
    if (hold_off_left != 0) begin
      m_axis_tready = 1'b0;
      hold_off_left--;
    end else begin
      if (pattern_age == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pattern = '1;
          1: stall_pattern = $urandom;
          2: stall_pattern = $urandom | $urandom;
          default: stall_pattern = ($urandom & $urandom) | 32'd1;
        endcase
        pattern_age = $urandom_range(32, 160);
      end
      m_axis_tready = stall_pattern[pattern_pos];
      pattern_pos++;
      pattern_age--;
    end
  end

  task automatic send_request(input logic [1:0] op, input logic [31:0] lo,
                              input logic [31:0] hi);
    @(negedge clk);
    if (gaps_on && burst_left == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {6'd0, hi, lo, op};
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(predict_result(op, lo, hi));
    if (burst_left > 0) burst_left--;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [63:0] value);
    wait_idle();
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    seed_reg = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic test_reset_state();
    repeat (3) send_request(OP_DRAW, $urandom, $urandom);
    send_request(OP_UNUSED, $urandom, $urandom);
  endtask

  task automatic test_reseed();
    logic [63:0] seeds [3];
    seeds[0] = '0;
    seeds[1] = '1;
    seeds[2] = {$urandom, $urandom};
    foreach (seeds[i]) begin
      write_seed(seeds[i]);
      send_request(OP_RESEED, $urandom, $urandom);
      send_request(OP_DRAW, $urandom, $urandom);
    end
  endtask

  task automatic test_bounded_edges();
    send_request(OP_BOUNDED, 32'h8000_0000, 32'h7fff_ffff);  // full span
    send_request(OP_BOUNDED, 32'h0000_0000, 32'hffff_ffff);  // full span, wrapped
    send_request(OP_BOUNDED, 32'h8000_0000, 32'h8000_0000);
    send_request(OP_BOUNDED, 32'h7fff_ffff, 32'h7fff_ffff);
    send_request(OP_BOUNDED, 32'h7fff_ffff, 32'h8000_0000);  // span of two across the sign boundary
    send_request(OP_BOUNDED, 32'hffff_ffff, 32'h0000_0000);
    send_request(OP_BOUNDED, 32'h0000_1000, 32'h0000_0010);  // reversed bounds
    // span just over half: nearly half the draws fall in the rejection band
    repeat (4) send_request(OP_BOUNDED, 32'h0000_0000, 32'h8000_0000);
    send_request(OP_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    @(posedge clk);
    hold_off_req = HOLD_OFF_CYCLES;
    repeat (24) begin
      if ($urandom_range(0, 1) == 0) send_request(OP_DRAW, $urandom, $urandom);
      else send_request(OP_BOUNDED, $urandom, $urandom);
    end
    wait_idle();
    gaps_on = 1'b1;
  endtask

  task automatic test_random();
    int pick;
    logic [1:0] op;
    logic [31:0] lo;
    logic [31:0] hi;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_seed('0);
        1: write_seed('1);
        default: write_seed({$urandom, $urandom});
      endcase
      gaps_on = (phase % 3) != 2;
      repeat (200) begin
        pick = $urandom_range(0, 99);
        lo = $urandom;
        hi = $urandom;
        if (pick < 40) op = OP_DRAW;
        else if (pick < 85) op = OP_BOUNDED;
        else if (pick < 95) op = OP_RESEED;
        else op = OP_UNUSED;
        if (op == OP_BOUNDED) begin
          case ($urandom_range(0, 4))
            0: hi = lo + $urandom_range(0, 100);
            1: ;
            2: hi = lo + 32'h7fff_ffff + $urandom_range(1, 65536);
            3: hi = lo - 32'd1;
            default: hi = lo - $urandom_range(2, 1000);
          endcase
        end
        send_request(op, lo, hi);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_state();
    test_reseed();
    test_bounded_edges();
    test_backpressure();
    test_random();
    wait_idle();
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
